// ===== rtl/core/cobs_frame_decoder_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef COBS_FRAME_DECODER_UNIT_ASSERT_SVH
`define COBS_FRAME_DECODER_UNIT_ASSERT_SVH

// checked property, masked while reset is asserted
`define CFDU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// checked property that also holds during reset
`define CFDU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/core/cobsd_pkg.sv =====
// types and constants of the cobs frame decoder
`timescale 1ns / 1ps

package cobsd_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CAP_W   = 16;
  localparam logic [7:0]  CODE_FULL = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CODE_DELIM = 3'd1,
    ST_OVERRUN    = 3'd2,
    ST_CAPACITY   = 3'd3,
    ST_BAD_CLOSER = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_DELIMITER = 1'b0,
    CFG_CAPACITY  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               is_status;
    logic [2:0]         frame_status;
    logic [COUNT_W-1:0] decoded_count;
  } out_rsp_t;

endpackage

// ===== rtl/core/cobsd_front.sv =====
// front end: per-byte decode state and generation of result requests
`timescale 1ns / 1ps

module cobsd_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cobsd_pkg::in_req_t           in_data_i,
  input  logic [7:0]                   delim_i,
  input  logic [cobsd_pkg::CAP_W-1:0]  cap_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output cobsd_pkg::out_rsp_t          push_data_o
);

  localparam int unsigned CMP_W =
    (LENGTH_BITS > cobsd_pkg::CAP_W) ? LENGTH_BITS : cobsd_pkg::CAP_W;

  logic [7:0]             owed_q, owed_d;
  logic                   due_q, due_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  cobsd_pkg::status_e     err_q, err_d;
  cobsd_pkg::status_e     close_st;

  logic             take;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] cap_ext;
  logic             cap_hit;

  assign in_ready_o = push_ready_i;
  assign take       = in_valid_i && push_ready_i;

  // limit is capacity clipped to what the length counter can hold
  assign len_ext = CMP_W'(len_q);
  assign cap_ext = CMP_W'(cap_i);
  assign cap_hit = (len_ext >= cap_ext) || (&len_q);

  // first error wins, then open block, then closer mismatch
  always_comb begin
    close_st = err_q;
    if (close_st == cobsd_pkg::ST_OK && owed_q != 8'd0) begin
      close_st = cobsd_pkg::ST_OVERRUN;
    end
    if (close_st == cobsd_pkg::ST_OK && in_data_i.in_byte != delim_i) begin
      close_st = cobsd_pkg::ST_BAD_CLOSER;
    end
  end

  always_comb begin
    owed_d       = owed_q;
    due_d        = due_q;
    len_d        = len_q;
    err_d        = err_q;
    push_valid_o = 1'b0;
    push_data_o  = '0;
    if (take) begin
      if (in_data_i.frame_end) begin
        push_valid_o              = 1'b1;
        push_data_o.is_status     = 1'b1;
        push_data_o.frame_status  = close_st;
        push_data_o.decoded_count = len_ext[cobsd_pkg::COUNT_W-1:0];
        owed_d = 8'd0;
        due_d  = 1'b0;
        len_d  = '0;
        err_d  = cobsd_pkg::ST_OK;
      end else if (err_q == cobsd_pkg::ST_OK) begin
        if (owed_q != 8'd0) begin
          // data byte of the current block
          if (cap_hit) begin
            err_d = cobsd_pkg::ST_CAPACITY;
          end else begin
            len_d                = len_q + 1'b1;
            owed_d               = owed_q - 8'd1;
            push_valid_o         = 1'b1;
            push_data_o.out_byte = in_data_i.in_byte;
          end
        end else if (due_q && cap_hit) begin
          err_d = cobsd_pkg::ST_CAPACITY;
        end else begin
          // code byte, restoring the delimiter of the previous block first
          if (due_q) begin
            len_d                = len_q + 1'b1;
            due_d                = 1'b0;
            push_valid_o         = 1'b1;
            push_data_o.out_byte = delim_i;
          end
          if (in_data_i.in_byte == delim_i) begin
            err_d = cobsd_pkg::ST_CODE_DELIM;
          end else if (in_data_i.in_byte == 8'd0) begin
            err_d = cobsd_pkg::ST_OVERRUN;
          end else begin
            owed_d = in_data_i.in_byte - 8'd1;
            due_d  = (in_data_i.in_byte != cobsd_pkg::CODE_FULL);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= 8'd0;
      due_q  <= 1'b0;
      len_q  <= '0;
      err_q  <= cobsd_pkg::ST_OK;
    end else begin
      owed_q <= owed_d;
      due_q  <= due_d;
      len_q  <= len_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== rtl/core/cobsd_queue.sv =====
// two-entry queue between the decode front end and the output stage
`timescale 1ns / 1ps

module cobsd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  cobsd_pkg::out_rsp_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output cobsd_pkg::out_rsp_t pop_data_o
);

  cobsd_pkg::out_rsp_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

// ===== rtl/core/cobsd_back.sv =====
// back end: output register that hands results to the consumer
`timescale 1ns / 1ps

module cobsd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  cobsd_pkg::out_rsp_t pop_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cobsd_pkg::out_rsp_t out_data_o
);

  logic                out_valid_q;
  cobsd_pkg::out_rsp_t out_data_q;

  // refill whenever the register is empty or being drained
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      out_data_q <= pop_data_i;
    end
  end

endmodule

// ===== rtl/core/cobs_frame_decoder_unit.sv =====
// Streaming COBS frame decoder. One encoded byte is accepted per clock cycle
// while the queue has room; its result, a decoded byte or frame-end status,
// goes via the two-entry queue to the output register. The rate is set by
// the front end's per-byte update of block counter, pending-delimiter flag,
// length counter, error latch. The two buffers keep input moving while the
// consumer stalls, and input ready drops only once both are full. Decoded
// bytes come out before the status item, so a frame whose status is not
// zero must be discarded by the receiver. Configuration writes are accepted
// at any cycle and are meant to happen only while no frame is in flight.
`timescale 1ns / 1ps

module cobs_frame_decoder_unit #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cobsd_pkg::in_req_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cobsd_pkg::out_rsp_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [cobsd_pkg::CAP_W-1:0] cfg_wdata_i
);

  logic [7:0]                  delim_q;
  logic [cobsd_pkg::CAP_W-1:0] cap_q;

  logic                push_valid, push_ready;
  cobsd_pkg::out_rsp_t push_data;
  logic                pop_valid, pop_ready;
  cobsd_pkg::out_rsp_t pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= 8'd0;
      cap_q   <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cobsd_pkg::CFG_DELIMITER) begin
        delim_q <= cfg_wdata_i[7:0];
      end else begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  cobsd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .delim_i      (delim_q),
    .cap_i        (cap_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cobsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cobsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/cobsd_checker.sv =====
// port checker for the cobs frame decoder and its bind
`timescale 1ns / 1ps
`include "cobs_frame_decoder_unit_assert.svh"

module cobsd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cobsd_pkg::out_rsp_t out_data_o
);

  `CFDU_ASSERT(a_out_held, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o,
    "result request dropped while stalled")
  `CFDU_ASSERT(a_out_stable, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> $stable(out_data_o),
    "result payload changed while stalled")
  `CFDU_ASSERT(a_data_clean, clk_i, rst_ni,
    out_valid_o && !out_data_o.is_status |->
      out_data_o.frame_status == 3'd0 && out_data_o.decoded_count == 16'd0,
    "data result carries status fields")
  `CFDU_ASSERT_ALWAYS(a_full_has_out, clk_i,
    !in_ready_o |-> out_valid_o,
    "input blocked with no result offered")

endmodule

bind cobs_frame_decoder_unit cobsd_checker u_cobsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
